FILE: rtl/core/assert_macros.svh
// Assertion macros for the RTL of the endpoint allocator, used by its top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock, masked while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never hold on a rising clock outside of reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: rtl/core/uea_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package uea_pkg;

  // Highest endpoint number managed by the allocator.
  localparam int MAX_EP = 6;
  localparam int MASK_W = MAX_EP + 1;
  localparam int EP_W = $clog2(MASK_W);
  localparam int CNT_W = $clog2(MAX_EP + 1);

  // Request field widths.
  localparam int FUNC_W = 3;
  localparam int REQ_W = 8;
  localparam int GIVEN_W = 3;

  // Request codes.
  localparam logic [FUNC_W-1:0] FUNC_RSV_IN = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_RSV_OUT = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_ALLOC_DUPLEX = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_ALLOC_IN = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_ALLOC_OUT = 3'd4;

  // IN FIFO limits without and with the CDC interface.
  localparam logic [CNT_W-1:0] FIFO_LIMIT_PLAIN = CNT_W'(4);
  localparam logic [CNT_W-1:0] FIFO_LIMIT_CDC = CNT_W'(5);

  typedef logic [MASK_W-1:0] mask_t;

  // Bits that allocation may hand out: every number except zero.
  localparam mask_t ALLOC_MASK = mask_t'({MASK_W{1'b1}} << 1);

  // Outcome of one request, including the updated masks.
  typedef struct packed {
    logic               ok;
    logic [GIVEN_W-1:0] given;
    mask_t              in_used_nxt;
    mask_t              out_used_nxt;
  } decision_t;

  // Lowest set bit of a candidate vector, zero if none is set.
  function automatic logic [EP_W-1:0] lowest_set(input mask_t vec);
    logic [EP_W-1:0] idx;
    idx = '0;
    for (int i = MAX_EP; i >= 1; i--) begin
      if (vec[i]) begin
        idx = EP_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/uea_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Request channel: one transfer carries one allocator request.
interface uea_in_if;
  logic                         valid;
  logic                         ready;
  logic [uea_pkg::FUNC_W-1:0]   func;
  logic [uea_pkg::REQ_W-1:0]    endpoint_req;

  modport source (output valid, output func, output endpoint_req, input ready);
  modport sink (input valid, input func, input endpoint_req, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/uea_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Result channel: one transfer carries the outcome of one request.
interface uea_out_if;
  logic                         valid;
  logic                         ready;
  logic                         success;
  logic [uea_pkg::GIVEN_W-1:0]  endpoint_given;

  modport source (output valid, output success, output endpoint_given, input ready);
  modport sink (input valid, input success, input endpoint_given, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/uea_decide.sv
`timescale 1ns / 1ps
`default_nettype none

// Decides one request against the current used-masks.
module uea_decide (
  input  wire logic [uea_pkg::FUNC_W-1:0] func,
  input  wire logic [uea_pkg::REQ_W-1:0]  endpoint_req,
  input  wire logic                       cdc_present,
  input  wire uea_pkg::mask_t             in_used,
  input  wire uea_pkg::mask_t             out_used,
  output uea_pkg::decision_t              dec
);

  logic                           req_in_range;
  logic [uea_pkg::EP_W-1:0]       req_idx;
  uea_pkg::mask_t                 req_bit;
  logic [uea_pkg::CNT_W-1:0]      in_count;
  logic                           fifo_room;
  logic [uea_pkg::EP_W-1:0]       pick_duplex;
  logic [uea_pkg::EP_W-1:0]       pick_in_pref;
  logic [uea_pkg::EP_W-1:0]       pick_in_any;
  logic [uea_pkg::EP_W-1:0]       pick_out_pref;
  logic [uea_pkg::EP_W-1:0]       pick_out_any;
  logic [uea_pkg::EP_W-1:0]       pick;
  uea_pkg::mask_t                 pick_bit;

  // Reservation target: only numbers up to the maximum are valid.
  assign req_in_range = endpoint_req <= uea_pkg::REQ_W'(uea_pkg::MAX_EP);
  assign req_idx = endpoint_req[uea_pkg::EP_W-1:0];
  assign req_bit = uea_pkg::mask_t'(1) << req_idx;

  // Count of IN numbers in use, number zero excluded.
  always_comb begin
    in_count = '0;
    for (int i = 1; i <= uea_pkg::MAX_EP; i++) begin
      in_count = in_count + uea_pkg::CNT_W'(in_used[i]);
    end
  end

  assign fifo_room = in_count < (cdc_present ? uea_pkg::FIFO_LIMIT_CDC
                                             : uea_pkg::FIFO_LIMIT_PLAIN);

  // Priority picks over the allocatable numbers.
  assign pick_duplex = uea_pkg::lowest_set(~(in_used | out_used) & uea_pkg::ALLOC_MASK);
  assign pick_in_pref = uea_pkg::lowest_set(~in_used & out_used & uea_pkg::ALLOC_MASK);
  assign pick_in_any = uea_pkg::lowest_set(~in_used & uea_pkg::ALLOC_MASK);
  assign pick_out_pref = uea_pkg::lowest_set(~out_used & in_used & uea_pkg::ALLOC_MASK);
  assign pick_out_any = uea_pkg::lowest_set(~out_used & uea_pkg::ALLOC_MASK);

  // Number chosen by the allocating requests; zero means none.
  always_comb begin
    case (func)
      uea_pkg::FUNC_ALLOC_DUPLEX: begin
        pick = fifo_room ? pick_duplex : '0;
      end
      uea_pkg::FUNC_ALLOC_IN: begin
        pick = !fifo_room ? '0 : ((pick_in_pref != '0) ? pick_in_pref : pick_in_any);
      end
      uea_pkg::FUNC_ALLOC_OUT: begin
        pick = (pick_out_pref != '0) ? pick_out_pref : pick_out_any;
      end
      default: begin
        pick = '0;
      end
    endcase
  end

  assign pick_bit = (pick != '0) ? (uea_pkg::mask_t'(1) << pick) : '0;

  // Outcome and mask updates.
  always_comb begin
    dec.ok = 1'b0;
    dec.given = uea_pkg::GIVEN_W'(pick);
    dec.in_used_nxt = in_used;
    dec.out_used_nxt = out_used;
    case (func)
      uea_pkg::FUNC_RSV_IN: begin
        dec.ok = req_in_range && ((in_used & req_bit) == '0);
        if (dec.ok) begin
          dec.in_used_nxt = in_used | req_bit;
        end
      end
      uea_pkg::FUNC_RSV_OUT: begin
        dec.ok = req_in_range && ((out_used & req_bit) == '0);
        if (dec.ok) begin
          dec.out_used_nxt = out_used | req_bit;
        end
      end
      uea_pkg::FUNC_ALLOC_DUPLEX: begin
        dec.ok = pick != '0;
        dec.in_used_nxt = in_used | pick_bit;
        dec.out_used_nxt = out_used | pick_bit;
      end
      uea_pkg::FUNC_ALLOC_IN: begin
        dec.ok = pick != '0;
        dec.in_used_nxt = in_used | pick_bit;
      end
      uea_pkg::FUNC_ALLOC_OUT: begin
        dec.ok = pick != '0;
        dec.out_used_nxt = out_used | pick_bit;
      end
      default: begin
        dec.ok = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/core/usb_endpoint_allocator.sv
// USB endpoint number allocator.
// Requests arrive on in_ch (func, endpoint_req) with a valid/ready handshake;
// each accepted transfer yields exactly one result transfer on out_ch
// (success, endpoint_given), in request order.
// cfg_we/cfg_wdata write the CDC-present bit, which raises the IN FIFO limit
// from four to five; write it only while no request is in flight.
// Pipeline: a request is captured in an input register, decided
// combinationally from it and loaded into the result register, which drives
// out_ch. Throughput is one request per cycle while out_ch does not stall;
// the used-masks update in the same cycle the result register loads, so
// back to back requests see each other's effect.
// When out_ch stalls, the result register holds and the input register
// holds its request; in_ch.ready drops only while both are full.
// Reset (rst_n low, synchronous) clears both used-masks, the CDC bit and all
// pending transfers.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module usb_endpoint_allocator (
  input  wire logic   clk,
  input  wire logic   rst_n,
  uea_in_if.sink      in_ch,
  uea_out_if.source   out_ch,
  input  wire logic   cfg_we,
  input  wire logic   cfg_wdata
);

  logic                         req_valid_r;
  logic [uea_pkg::FUNC_W-1:0]   req_func_r;
  logic [uea_pkg::REQ_W-1:0]    req_ep_r;
  logic                         res_valid_r;
  logic                         res_success_r;
  logic [uea_pkg::GIVEN_W-1:0]  res_given_r;
  uea_pkg::mask_t               in_used_r;
  uea_pkg::mask_t               out_used_r;
  logic                         cdc_present_r;
  logic                         advance;
  logic                         in_accept;
  uea_pkg::decision_t           dec;

  // Pipeline control: the decision moves when the result slot is free.
  assign advance = req_valid_r && (!res_valid_r || out_ch.ready);
  assign in_ch.ready = !req_valid_r || advance;
  assign in_accept = in_ch.valid && in_ch.ready;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      req_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      req_func_r <= in_ch.func;
      req_ep_r <= in_ch.endpoint_req;
    end
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cdc_present_r <= 1'b0;
    end else if (cfg_we) begin
      cdc_present_r <= cfg_wdata;
    end
  end

  uea_decide u_decide (
    .func         (req_func_r),
    .endpoint_req (req_ep_r),
    .cdc_present  (cdc_present_r),
    .in_used      (in_used_r),
    .out_used     (out_used_r),
    .dec          (dec)
  );

  // Used-masks commit together with the result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_used_r <= '0;
      out_used_r <= '0;
    end else if (advance) begin
      in_used_r <= dec.in_used_nxt;
      out_used_r <= dec.out_used_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (advance) begin
      res_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      res_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_success_r <= dec.ok;
      res_given_r <= dec.given;
    end
  end

  assign out_ch.valid = res_valid_r;
  assign out_ch.success = res_success_r;
  assign out_ch.endpoint_given = res_given_r;

  // Masks only ever gain bits between resets.
  `ASSERT_CLK(a_masks_grow, clk, rst_n, 1'b1 |=> (((in_used_r & $past(in_used_r)) == $past(in_used_r)) && ((out_used_r & $past(out_used_r)) == $past(out_used_r))), "used-mask lost a bit")
  // A stalled request stays in the input register.
  `ASSERT_CLK(a_req_hold, clk, rst_n, (req_valid_r && !advance) |=> (req_valid_r && $stable(req_func_r) && $stable(req_ep_r)), "stalled request was dropped")
  // A failed request never reports an endpoint number.
  `ASSERT_NEVER(a_fail_no_ep, clk, rst_n, res_valid_r && !res_success_r && (res_given_r != '0), "failure reported with an endpoint")

endmodule

`default_nettype wire
